// ----- sv/hilbert_fir_with_matched_delay_defines.svh -----
// Assertion macros for the Hilbert FIR with matched delay.
// Used by hilbert_fir_with_matched_delay.sv; expects clk and arst_n in scope.
`ifndef HILBERT_FIR_WITH_MATCHED_DELAY_DEFINES_SVH
`define HILBERT_FIR_WITH_MATCHED_DELAY_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HFMD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define HFMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/hfmd_pkg.sv -----
// Package for the Hilbert FIR with matched delay: sizes, register codes and
// the Kaiser-windowed Hilbert tap ROM built at elaboration. No dependencies.
package hfmd_pkg;

	localparam int HALF_LENGTH  = 64;
	localparam int TAP_TOTAL    = 2 * HALF_LENGTH + 1;
	localparam int SAMPLE_BITS  = 24;
	localparam int TAP_FRAC     = 23;
	localparam int TAP_BITS     = TAP_FRAC + 1;
	localparam int SERIES_TERMS = 32;

	localparam int PTR_BITS       = $clog2(TAP_TOTAL);
	localparam int ALIGN_PTR_BITS = (HALF_LENGTH > 1) ? $clog2(HALF_LENGTH) : 1;

	// Nonzero taps sit at odd offsets from the center tap
	localparam int T_FIRST = (HALF_LENGTH + 1) % 2;
	localparam int T_LAST  = TAP_TOTAL - 1 - T_FIRST;
	localparam int NZ_TAPS = (T_LAST - T_FIRST) / 2 + 1;

	localparam int PROD_BITS = SAMPLE_BITS + TAP_BITS;
	localparam int ACC_BITS  = PROD_BITS + $clog2(TAP_TOTAL) + 1;

	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 8;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DIRECTION_NEGATIVE = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_ENABLE       = CFG_INDEX_BITS'(1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [TAP_BITS-1:0] tap_t;
	typedef logic [TAP_TOTAL-1:0][TAP_BITS-1:0] tap_rom_t;

	typedef struct packed {
		logic [63:0] quo;
		logic [63:0] rem;
	} divmod_t;

	// Unsigned 64-bit restoring division, elaboration only
	function automatic divmod_t long_divide(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] part;
		divmod_t     res;
		part = '0;
		res  = '0;
		for (int i = 63; i >= 0; i--) begin
			part    = {part[63:0], num[i]};
			res.quo = {res.quo[62:0], 1'b0};
			if (part >= {1'b0, den}) begin
				part       = part - {1'b0, den};
				res.quo[0] = 1'b1;
			end
		end
		res.rem = part[63:0];
		return res;
	endfunction

	// Fixed-point Kaiser (beta 8.6) Hilbert taps, unit gain at fs/4, Q1.23
	function automatic tap_rom_t build_taps();
		longint unsigned r [TAP_TOTAL];
		longint signed   total;
		longint signed   k;
		longint signed   v;
		longint unsigned l2;
		longint unsigned ak;
		longint unsigned q16;
		longint unsigned sum;
		longint unsigned term;
		longint unsigned g;
		longint unsigned quo;
		longint unsigned rem;
		longint unsigned mag;
		longint unsigned mag_max;
		divmod_t         dm;
		tap_rom_t        rom;
		total   = 0;
		l2      = longint'(HALF_LENGTH) * longint'(HALF_LENGTH);
		mag_max = (64'd1 << TAP_FRAC) - 64'd1;
		rom     = '0;
		for (int t = 0; t < TAP_TOTAL; t++) begin
			k    = longint'(t) - longint'(HALF_LENGTH);
			ak   = (k < 0) ? longint'(-k) : longint'(k);
			q16  = 0;
			r[t] = 0;
			if (ak[0]) begin
				if (ak * ak < l2) begin
					dm  = long_divide((64'd1849 * (l2 - ak * ak)) << 16, 64'd100 * l2);
					q16 = dm.quo;
				end
				sum  = 64'd1 << 32;
				term = 64'd1 << 32;
				for (int m = 1; m < SERIES_TERMS; m++) begin
					dm   = long_divide((term * q16) >> 16, longint'(m) * longint'(m));
					term = dm.quo;
					sum  = sum + term;
				end
				dm   = long_divide(sum, ak);
				r[t] = dm.quo;
				v = longint'(r[t]);
				if (k < 0)
					v = -v;
				if (t[1])
					v = -v;
				total = total + v;
			end
		end
		g = (total < 0) ? longint'(-total) : longint'(total);
		for (int t = 0; t < TAP_TOTAL; t++) begin
			if (g != 0 && r[t] != 0) begin
				dm  = long_divide(r[t], g);
				quo = dm.quo;
				rem = dm.rem;
				for (int i = 0; i < TAP_FRAC + 1; i++) begin
					rem = rem << 1;
					quo = quo << 1;
					if (rem >= g) begin
						rem = rem - g;
						quo = quo | 64'd1;
					end
				end
				mag = (quo + 64'd1) >> 1;
				if (mag > mag_max)
					mag = mag_max;
				v = (t < HALF_LENGTH) ? -longint'(mag) : longint'(mag);
				rom[t] = TAP_BITS'(v);
			end
		end
		return rom;
	endfunction

	localparam tap_rom_t TAP_ROM = build_taps();

endpackage

// ----- sv/hfmd_ifs.sv -----
// Channel interfaces for the Hilbert FIR with matched delay: sample input,
// result output and configuration write. Depends on hfmd_pkg.
interface hfmd_in_if import hfmd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t shifted_in;
	sample_t aligned_in;
	modport source(output valid, output shifted_in, output aligned_in, input ready);
	modport sink(input valid, input shifted_in, input aligned_in, output ready);
endinterface

interface hfmd_out_if import hfmd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t shifted_out;
	sample_t aligned_out;
	modport source(output valid, output shifted_out, output aligned_out, input ready);
	modport sink(input valid, input shifted_out, input aligned_out, output ready);
endinterface

interface hfmd_cfg_if import hfmd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- sv/hilbert_fir_with_matched_delay.sv -----
// A single shared multiply-accumulate walks the odd taps, one history memory read per
// cycle; a muted shifted path skips the walk. A new transaction is accepted only once
// the previous one has left ST_DONE. Results park in an output register; a result held
// back by the sink stalls the next one in ST_DONE until the sink takes it.
// Reset (arst_n, async, active low): history and delay line read as zero until
// written (fill flags, no clearing pass), pointers zero, shift_enable 1.
// Top level of the Hilbert FIR with matched delay.
// Depends on hfmd_pkg, hfmd_ifs and hilbert_fir_with_matched_delay_defines.svh.
`include "hilbert_fir_with_matched_delay_defines.svh"

module hilbert_fir_with_matched_delay import hfmd_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	hfmd_cfg_if.sink    cfg,
	hfmd_in_if.sink     samples,
	hfmd_out_if.source  results
);

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_NEG   = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [PTR_BITS-1:0] T_FIRST_IDX  = PTR_BITS'(T_FIRST);
	localparam logic [PTR_BITS-1:0] T_LAST_IDX   = PTR_BITS'(T_LAST);
	localparam logic [PTR_BITS-1:0] HIST_LAST    = PTR_BITS'(TAP_TOTAL - 1);
	localparam logic [PTR_BITS-1:0] HIST_WRAP2   = PTR_BITS'(TAP_TOTAL - 2);
	localparam logic [PTR_BITS-1:0] HIST_WRAPF   = PTR_BITS'(TAP_TOTAL - T_FIRST);
	localparam logic [PTR_BITS-1:0] STEP_TWO     = PTR_BITS'(2);
	localparam logic [ALIGN_PTR_BITS-1:0] ALIGN_LAST = ALIGN_PTR_BITS'(HALF_LENGTH - 1);

	localparam int SCALED_BITS = ACC_BITS - TAP_FRAC;
	localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
		ACC_BITS'(longint'(1) << (TAP_FRAC - 1));
	localparam logic signed [SCALED_BITS-1:0] SAT_HI =
		SCALED_BITS'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SCALED_BITS-1:0] SAT_LO = -SAT_HI - SCALED_BITS'(1);

	// ---------------------------------------------------------------------
	// Configuration registers; writes land only while the block is idle
	// ---------------------------------------------------------------------
	logic dir_neg_q;
	logic shift_en_q;
	logic [2:0] state_q;

	assign cfg.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_neg_q  <= 1'b0;
			shift_en_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_DIRECTION_NEGATIVE: dir_neg_q  <= cfg.data[0];
				REG_SHIFT_ENABLE:       shift_en_q <= cfg.data[0];
				default: ; // unknown index: dropped
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------------
	logic [PTR_BITS-1:0]       hist_ptr_q;
	logic                      hist_wrap_q;   // every history entry written once
	logic [ALIGN_PTR_BITS-1:0] align_ptr_q;
	logic                      align_wrap_q;  // every delay entry written once
	logic                      align_live_q;  // delay read came from a written entry
	logic [PTR_BITS-1:0]       t_q;           // tap index being issued
	logic [PTR_BITS-1:0]       idx_q;         // history address for that tap
	logic                      v_s1;
	logic                      v_s2;
	logic                      live_s1;
	logic                      out_valid_q;

	// Payload
	sample_t                       hist_rdata_s1;
	tap_t                          tap_s1;
	logic signed [PROD_BITS-1:0]   prod_s2;
	logic signed [ACC_BITS-1:0]    acc_q;
	sample_t                       res_q;
	sample_t                       align_rdata_q;
	sample_t                       shifted_out_q;
	sample_t                       aligned_out_q;

	logic in_accept;
	logic out_free;
	logic hist_we;
	logic hist_re;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_accept     = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || results.ready;
	assign hist_we       = in_accept && shift_en_q;
	assign hist_re       = (state_q == ST_MAC);

	// ---------------------------------------------------------------------
	// Memories: shifted-path history and the aligned-path delay line
	// ---------------------------------------------------------------------
	sample_t hist_mem  [TAP_TOTAL];
	sample_t align_mem [HALF_LENGTH];

	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[hist_ptr_q] <= samples.shifted_in;
		if (hist_re)
			hist_rdata_s1 <= hist_mem[idx_q];
	end

	// Read-first: the old entry leaves as this one goes in
	always_ff @(posedge clk) begin
		if (in_accept) begin
			align_rdata_q          <= align_mem[align_ptr_q];
			align_mem[align_ptr_q] <= samples.aligned_in;
		end
	end

	// ---------------------------------------------------------------------
	// Round and saturate of the final accumulator
	// ---------------------------------------------------------------------
	logic signed [ACC_BITS-1:0]    rounded;
	logic signed [SCALED_BITS-1:0] scaled;
	sample_t                       saturated;

	always_comb begin
		rounded = acc_q + ROUND_HALF;
		scaled  = rounded[ACC_BITS-1:TAP_FRAC];
		priority if (scaled > SAT_HI)
			saturated = SAMPLE_BITS'(SAT_HI);
		else if (scaled < SAT_LO)
			saturated = SAMPLE_BITS'(SAT_LO);
		else
			saturated = SAMPLE_BITS'(scaled);
	end

	// ---------------------------------------------------------------------
	// Sequencer: accept, walk odd taps, drain MAC pipe, sign, round, deliver (muted: accept, deliver)
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			hist_ptr_q   <= '0;
			hist_wrap_q  <= 1'b0;
			align_ptr_q  <= '0;
			align_wrap_q <= 1'b0;
			align_live_q <= 1'b0;
			t_q          <= '0;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			live_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			v_s1    <= hist_re;
			v_s2    <= v_s1;
			live_s1 <= hist_wrap_q || (idx_q <= hist_ptr_q);

			// result register: loaded when done, held until the sink takes it
			out_valid_q <= (state_q == ST_DONE && out_free) ||
				(out_valid_q && !results.ready);

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						align_live_q <= align_wrap_q;
						if (align_ptr_q == ALIGN_LAST) begin
							align_ptr_q  <= '0;
							align_wrap_q <= 1'b1;
						end else begin
							align_ptr_q <= align_ptr_q + ALIGN_PTR_BITS'(1);
						end
						t_q   <= T_FIRST_IDX;
						idx_q <= (hist_ptr_q >= T_FIRST_IDX) ? hist_ptr_q - T_FIRST_IDX
							: hist_ptr_q + HIST_WRAPF;
						// muted path: no filtering, history frozen
						state_q <= shift_en_q ? ST_MAC : ST_DONE;
					end
				end
				ST_MAC: begin
					t_q   <= t_q + STEP_TWO;
					idx_q <= (idx_q >= STEP_TWO) ? idx_q - STEP_TWO : idx_q + HIST_WRAP2;
					if (t_q == T_LAST_IDX)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2)
						state_q <= ST_NEG;
				end
				ST_NEG: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (hist_ptr_q == HIST_LAST) begin
						hist_ptr_q  <= '0;
						hist_wrap_q <= 1'b1;
					end else begin
						hist_ptr_q <= hist_ptr_q + PTR_BITS'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: tap fetch, multiply, accumulate, result
	always_ff @(posedge clk) begin
		if (hist_re)
			tap_s1 <= tap_t'(TAP_ROM[t_q]);
		if (live_s1)
			prod_s2 <= hist_rdata_s1 * tap_s1;
		else
			prod_s2 <= '0;
		if (in_accept)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + ACC_BITS'(prod_s2);
		else if (state_q == ST_NEG && !dir_neg_q)
			acc_q <= -acc_q;
		if (in_accept)
			res_q <= '0;
		else if (state_q == ST_ROUND)
			res_q <= saturated;
		if (state_q == ST_DONE && out_free) begin
			shifted_out_q <= res_q;
			aligned_out_q <= align_live_q ? align_rdata_q : '0;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.shifted_out = shifted_out_q;
	assign results.aligned_out = aligned_out_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`HFMD_ASSERT_SAME(a_tap_walk_bounded, state_q == ST_MAC, t_q <= T_LAST_IDX, "tap walk past last tap")
	`HFMD_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_q != ST_IDLE, "accept did not start work")
	`HFMD_ASSERT_SAME(a_mac_pipe_in_walk, v_s2, state_q == ST_MAC || state_q == ST_DRAIN, "MAC product outside walk")

endmodule
